/* rtl/smr_pkg.sv */
// ----------------------------------------------------------------------------
// smr_pkg
// Shared types, address map and reset values of the mailbox register block.
// ----------------------------------------------------------------------------
package smr_pkg;

    typedef enum logic [1:0] {
        OP_BUS_READ   = 2'd0,
        OP_BUS_WRITE  = 2'd1,
        OP_SCRATCH_SET = 2'd2,
        OP_SCRATCH_GET = 2'd3
    } op_t;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned RAM_DEPTH = 64;
    localparam int unsigned RAM_AW  = $clog2(RAM_DEPTH);
    localparam int unsigned REG_IW  = 3;
    localparam int unsigned SCR_IW  = 5;

    // mapped bus addresses
    localparam logic [DATA_W-1:0] ADDR_M2S_CMD  = 32'h1000_F200;
    localparam logic [DATA_W-1:0] ADDR_S2M_CMD  = 32'h1000_F210;
    localparam logic [DATA_W-1:0] ADDR_MAIN_FLG = 32'h1000_F220;
    localparam logic [DATA_W-1:0] ADDR_SUB_FLG  = 32'h1000_F230;
    localparam logic [DATA_W-1:0] ADDR_CONTROL  = 32'h1000_F240;
    localparam logic [DATA_W-1:0] ADDR_DESC     = 32'h1000_F260;

    // register slots in the lower half of the state ram
    localparam logic [REG_IW-1:0] REG_M2S_CMD  = 3'd0;
    localparam logic [REG_IW-1:0] REG_S2M_CMD  = 3'd1;
    localparam logic [REG_IW-1:0] REG_MAIN_FLG = 3'd2;
    localparam logic [REG_IW-1:0] REG_SUB_FLG  = 3'd3;
    localparam logic [REG_IW-1:0] REG_CONTROL  = 3'd4;
    localparam logic [REG_IW-1:0] REG_DESC     = 3'd5;

    localparam logic [DATA_W-1:0] FLAG_RESET     = 32'h0001_0000 | 32'h0002_0000 | 32'h0004_0000;
    localparam logic [DATA_W-1:0] CONTROL_RESET  = 32'hF000_0102;
    localparam logic [DATA_W-1:0] CONTROL_FORCED = 32'hF000_0002;
    localparam logic [DATA_W-1:0] IOP_RAM_BASE_RESET = 32'd469762048;

    localparam logic [SCR_IW-1:0] SCR_RAM_BASE = 5'd2;
    localparam logic [SCR_IW-1:0] SCR_FLAG_A   = 5'd3;
    localparam logic [SCR_IW-1:0] SCR_FLAG_B   = 5'd4;

    typedef struct packed {
        logic              hit;
        logic [REG_IW-1:0] slot;
    } reg_decode_t;

    function automatic reg_decode_t decode_addr(input logic [DATA_W-1:0] addr);
        reg_decode_t d;
        d.hit  = 1'b1;
        d.slot = REG_M2S_CMD;
        case (addr)
            ADDR_M2S_CMD:  d.slot = REG_M2S_CMD;
            ADDR_S2M_CMD:  d.slot = REG_S2M_CMD;
            ADDR_MAIN_FLG: d.slot = REG_MAIN_FLG;
            ADDR_SUB_FLG:  d.slot = REG_SUB_FLG;
            ADDR_CONTROL:  d.slot = REG_CONTROL;
            ADDR_DESC:     d.slot = REG_DESC;
            default:       d.hit  = 1'b0;
        endcase
        return d;
    endfunction

    // value of a ram entry that was never written since reset
    function automatic logic [DATA_W-1:0] reset_value(input logic [RAM_AW-1:0] a);
        logic [DATA_W-1:0] v;
        v = '0;
        if (a[RAM_AW-1]) begin
            case (a[SCR_IW-1:0])
                SCR_RAM_BASE: v = IOP_RAM_BASE_RESET;
                SCR_FLAG_A:   v = FLAG_RESET;
                SCR_FLAG_B:   v = FLAG_RESET;
                default:      v = '0;
            endcase
        end else begin
            case (a[REG_IW-1:0])
                REG_MAIN_FLG: v = FLAG_RESET;
                REG_SUB_FLG:  v = FLAG_RESET;
                REG_CONTROL:  v = CONTROL_RESET;
                default:      v = '0;
            endcase
        end
        return v;
    endfunction

endpackage

/* rtl/smr_ram.sv */
// ----------------------------------------------------------------------------
// smr_ram
// Generic single-write, single-read synchronous ram with registered read.
// ----------------------------------------------------------------------------
module smr_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/subsystem_mailbox_registers.sv */
// ----------------------------------------------------------------------------
// subsystem_mailbox_registers
// Inter-processor mailbox registers and 32-word scratch file in one state ram.
// ----------------------------------------------------------------------------
// Each request is handled in turn: the state ram is read at the accept edge and
// the modified word is written back when the result enters the output
// register, which waits while an earlier result is still held. A new request
// is taken only once the write-back is done, so requests never overlap.
// The six mapped words sit in the lower half of the ram and the scratch words
// in the upper half; per-entry valid bits supply the reset values, so no
// clearing pass is needed after reset.
module subsystem_mailbox_registers (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [31:0] s_bus_address,
    input  logic [4:0]  s_word_index,
    input  logic [31:0] s_write_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_read_data
);

    localparam int unsigned AW = smr_pkg::RAM_AW;
    localparam int unsigned DW = smr_pkg::DATA_W;

    // control state
    logic                   busy_reg, busy_next;
    logic                   m_valid_reg, m_valid_next;
    logic [smr_pkg::RAM_DEPTH-1:0] valid_reg, valid_next;

    // request held during the write-back cycle
    smr_pkg::op_t           op_reg;
    logic                   hit_reg;
    logic [AW-1:0]          addr_reg;
    logic [DW-1:0]          wval_reg;
    logic [DW-1:0]          m_read_data_reg, m_read_data_next;

    smr_pkg::op_t           s_op;
    smr_pkg::reg_decode_t   dec;
    logic                   accept;
    logic                   advance;
    logic [AW-1:0]          req_addr;
    logic                   req_hit;

    logic                   ram_we;
    logic [DW-1:0]          ram_wdata;
    logic [DW-1:0]          ram_rdata;
    logic [DW-1:0]          cur;

    assign s_op    = smr_pkg::op_t'(s_opcode);
    assign dec     = smr_pkg::decode_addr(s_bus_address);
    assign s_ready = !busy_reg;
    assign accept  = s_valid && s_ready;
    assign advance = busy_reg && (!m_valid_reg || m_ready);

    always_comb begin
        if (s_op == smr_pkg::OP_SCRATCH_SET || s_op == smr_pkg::OP_SCRATCH_GET) begin
            req_addr = {1'b1, s_word_index};
            req_hit  = 1'b1;
        end else begin
            req_addr = {{(AW-smr_pkg::REG_IW){1'b0}}, dec.slot};
            req_hit  = dec.hit;
        end
    end

    // entries never written read as their reset value
    assign cur = valid_reg[addr_reg] ? ram_rdata : smr_pkg::reset_value(addr_reg);

    always_comb begin
        ram_we           = 1'b0;
        ram_wdata        = wval_reg;
        m_read_data_next = m_read_data_reg;
        if (advance) begin
            m_read_data_next = '0;
            case (op_reg)
                smr_pkg::OP_BUS_READ: begin
                    if (hit_reg) m_read_data_next = cur;
                end
                smr_pkg::OP_BUS_WRITE: begin
                    ram_we = hit_reg;
                    case (addr_reg[smr_pkg::REG_IW-1:0])
                        smr_pkg::REG_MAIN_FLG: ram_wdata = cur | wval_reg;
                        smr_pkg::REG_SUB_FLG:  ram_wdata = cur & ~wval_reg;
                        smr_pkg::REG_CONTROL:
                            ram_wdata = (cur & ~wval_reg) | smr_pkg::CONTROL_FORCED;
                        default:               ram_wdata = wval_reg;
                    endcase
                end
                smr_pkg::OP_SCRATCH_SET: begin
                    ram_we = 1'b1;
                end
                smr_pkg::OP_SCRATCH_GET: begin
                    m_read_data_next = cur;
                end
                default: begin
                    m_read_data_next = '0;
                end
            endcase
        end
    end

    always_comb begin
        busy_next    = busy_reg;
        m_valid_next = m_valid_reg;
        valid_next   = valid_reg;
        if (m_valid_reg && m_ready) m_valid_next = 1'b0;
        if (advance) begin
            busy_next    = 1'b0;
            m_valid_next = 1'b1;
        end
        if (accept) busy_next = 1'b1;
        if (ram_we) valid_next[addr_reg] = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            valid_reg   <= '0;
        end else begin
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
            valid_reg   <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg   <= s_op;
            hit_reg  <= req_hit;
            addr_reg <= req_addr;
            wval_reg <= s_write_value;
        end
        m_read_data_reg <= m_read_data_next;
    end

    smr_ram #(
        .WIDTH (DW),
        .DEPTH (smr_pkg::RAM_DEPTH)
    ) u_state_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (addr_reg),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (req_addr),
        .rdata (ram_rdata)
    );

    assign m_valid     = m_valid_reg;
    assign m_read_data = m_read_data_reg;

endmodule

/* rtl/smr_checker.sv */
// ----------------------------------------------------------------------------
// smr_checker
// Port-level checks of the mailbox register block, bound to the top level.
// ----------------------------------------------------------------------------
module smr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [1:0]  s_opcode,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_read_data
);

    // one request in flight at a time
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while another is in flight");

    // a result only appears after a request was taken
    a_result_after_request: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result without a pending request");

    // writes accepted while the output side is free return zero
    a_write_returns_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (!m_valid || m_ready) &&
         (s_opcode == smr_pkg::OP_BUS_WRITE || s_opcode == smr_pkg::OP_SCRATCH_SET))
        |-> ##2 (m_valid && m_read_data == 32'd0))
        else $error("write request did not return zero");

    // a stalled result holds
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_read_data))
        else $error("stalled result changed");

endmodule

bind subsystem_mailbox_registers smr_checker u_smr_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_opcode    (s_opcode),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_read_data (m_read_data)
);

/* bench/mailbox_checker.sv */
// ----------------------------------------------------------------------------
// mailbox_checker
// Watches both channels of the mailbox register block, keeps its own copy of
// the mapped words and the scratch file, and compares every returned word
// with the oldest predicted one.
// ----------------------------------------------------------------------------
module mailbox_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [31:0] s_bus_address,
    input  logic [4:0]  s_word_index,
    input  logic [31:0] s_write_value,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [31:0] m_read_data,
    output int          mismatches,
    output int          outstanding,
    output int          results_checked
);

    typedef struct {
        smr_pkg::op_t op;
        logic [31:0]  addr;
        logic [4:0]   idx;
        logic [31:0]  read_data;
    } access_t;

    access_t     expected_reads[$];

    logic [31:0] m2s_cmd;
    logic [31:0] s2m_cmd;
    logic [31:0] main_flags;
    logic [31:0] sub_flags;
    logic [31:0] control_word;
    logic [31:0] descriptor_word;
    logic [31:0] scratch_words [32];

    // applies one request to the mirror and returns the word it reads
    function automatic logic [31:0] perform_access(input smr_pkg::op_t op,
                                                   input logic [31:0] addr,
                                                   input logic [4:0] idx,
                                                   input logic [31:0] val);
        logic [31:0] rd;
        rd = '0;
        case (op)
            smr_pkg::OP_BUS_READ: begin
                case (addr)
                    smr_pkg::ADDR_M2S_CMD:  rd = m2s_cmd;
                    smr_pkg::ADDR_S2M_CMD:  rd = s2m_cmd;
                    smr_pkg::ADDR_MAIN_FLG: rd = main_flags;
                    smr_pkg::ADDR_SUB_FLG:  rd = sub_flags;
                    smr_pkg::ADDR_CONTROL:  rd = control_word;
                    smr_pkg::ADDR_DESC:     rd = descriptor_word;
                    default:                rd = '0;
                endcase
            end
            smr_pkg::OP_BUS_WRITE: begin
                case (addr)
                    smr_pkg::ADDR_M2S_CMD:  m2s_cmd = val;
                    smr_pkg::ADDR_S2M_CMD:  s2m_cmd = val;
                    smr_pkg::ADDR_MAIN_FLG: main_flags = main_flags | val;
                    smr_pkg::ADDR_SUB_FLG:  sub_flags = sub_flags & ~val;
                    smr_pkg::ADDR_CONTROL:
                        control_word = (control_word & ~val) | smr_pkg::CONTROL_FORCED;
                    smr_pkg::ADDR_DESC:     descriptor_word = val;
                    default:                ;
                endcase
            end
            smr_pkg::OP_SCRATCH_SET: scratch_words[idx] = val;
            default:                 rd = scratch_words[idx];
        endcase
        return rd;
    endfunction

    always @(posedge aclk) begin
        access_t acc;
        if (!aresetn) begin
            m2s_cmd         = '0;
            s2m_cmd         = '0;
            main_flags      = smr_pkg::FLAG_RESET;
            sub_flags       = smr_pkg::FLAG_RESET;
            control_word    = smr_pkg::CONTROL_RESET;
            descriptor_word = '0;
            for (int i = 0; i < 32; i++) scratch_words[i] = '0;
            scratch_words[smr_pkg::SCR_RAM_BASE] = smr_pkg::IOP_RAM_BASE_RESET;
            scratch_words[smr_pkg::SCR_FLAG_A]   = smr_pkg::FLAG_RESET;
            scratch_words[smr_pkg::SCR_FLAG_B]   = smr_pkg::FLAG_RESET;
            expected_reads.delete();
            mismatches      <= 0;
            outstanding     <= 0;
            results_checked <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_reads.size() == 0) begin
                    $display("%0t: read_data expected none, got %h", $time, m_read_data);
                    mismatches <= mismatches + 1;
                end else begin
                    acc = expected_reads.pop_front();
                    results_checked <= results_checked + 1;
                    if (m_read_data !== acc.read_data) begin
                        $display("%0t: read_data (%s addr %h idx %0d) expected %h, got %h",
                                 $time, acc.op.name(), acc.addr, acc.idx, acc.read_data,
                                 m_read_data);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            if (s_valid && s_ready) begin
                acc.op        = smr_pkg::op_t'(s_opcode);
                acc.addr      = s_bus_address;
                acc.idx       = s_word_index;
                acc.read_data = perform_access(acc.op, s_bus_address, s_word_index,
                                               s_write_value);
                expected_reads.push_back(acc);
            end
            outstanding <= expected_reads.size();
        end
    end

endmodule

/* bench/subsystem_mailbox_registers_tb.sv */
// ----------------------------------------------------------------------------
// subsystem_mailbox_registers_tb
// Drives bus reads and writes and scratch accesses into the mailbox register
// block with random gaps and result stalls; a checker beside the block
// predicts and compares every returned word.
// ----------------------------------------------------------------------------
module subsystem_mailbox_registers_tb;

    localparam int ITEMS_PER_PHASE = 110;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int WATCHDOG_LIMIT  = 2000;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_opcode;
    logic [31:0] s_bus_address;
    logic [4:0]  s_word_index;
    logic [31:0] s_write_value;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_read_data;

    int          mismatches;
    int          outstanding;
    int          results_checked;
    int          idle_cycles;
    int          op_count [4];
    bit          gaps_on;
    bit          hold_off_req;

    logic [31:0] mapped_addr [6] = '{smr_pkg::ADDR_M2S_CMD, smr_pkg::ADDR_S2M_CMD,
                                     smr_pkg::ADDR_MAIN_FLG, smr_pkg::ADDR_SUB_FLG,
                                     smr_pkg::ADDR_CONTROL, smr_pkg::ADDR_DESC};

    subsystem_mailbox_registers dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_bus_address (s_bus_address),
        .s_word_index  (s_word_index),
        .s_write_value (s_write_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_read_data   (m_read_data)
    );

    mailbox_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_bus_address   (s_bus_address),
        .s_word_index    (s_word_index),
        .s_write_value   (s_write_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_read_data     (m_read_data),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .results_checked (results_checked)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // offers one request, after a random gap when gaps_on is set, and returns at the accepting edge
    task automatic offer(input smr_pkg::op_t op, input logic [31:0] addr,
                         input logic [4:0] idx, input logic [31:0] val);
        int gap;
        gap = gaps_on ? $urandom_range(0, 12) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_opcode      <= op;
        s_bus_address <= addr;
        s_word_index  <= idx;
        s_write_value <= val;
        do @(posedge aclk); while (!s_ready);
        op_count[op]++;
    endtask

    // stop offering until every predicted word has come back
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    task automatic random_request();
        smr_pkg::op_t op;
        logic [31:0]  addr;
        logic [31:0]  val;
        int           pick;
        op   = smr_pkg::op_t'($urandom_range(0, 3));
        pick = $urandom_range(0, 9);
        if (pick <= 6) addr = mapped_addr[$urandom_range(0, 5)];
        else if (pick == 7) addr = $urandom;
        else if (pick == 8) addr = {mapped_addr[0][31:8], 8'($urandom)};
        // one bit away from a mapped address
        else addr = mapped_addr[$urandom_range(0, 5)] ^ (32'd1 << $urandom_range(0, 31));
        case ($urandom_range(0, 7))
            0:       val = '0;
            1:       val = '1;
            2:       val = 32'd1 << $urandom_range(0, 31);
            default: val = $urandom;
        endcase
        offer(op, addr, 5'($urandom_range(0, 31)), val);
    endtask

    // result side: random stalls, one long hold-off on request
    initial begin
        int stall;
        m_ready = 1'b0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall = HOLD_OFF_CYCLES;
            end else begin
                stall = gaps_on ? $urandom_range(0, 12) : 0;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: timeout, no handshake for %0d cycles", $time, idle_cycles);
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_opcode      = smr_pkg::OP_BUS_READ;
        s_bus_address = '0;
        s_word_index  = '0;
        s_write_value = '0;
        idle_cycles   = 0;
        gaps_on       = 1'b1;
        hold_off_req  = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset values, unmapped accesses, one write of each kind
        foreach (mapped_addr[i]) offer(smr_pkg::OP_BUS_READ, mapped_addr[i], 5'd0, 32'h0);
        offer(smr_pkg::OP_BUS_READ, 32'h1000_F250, 5'd31, 32'hFFFF_FFFF);
        offer(smr_pkg::OP_BUS_WRITE, 32'hFFFF_FFFF, 5'd31, 32'hFFFF_FFFF);
        offer(smr_pkg::OP_BUS_WRITE, 32'h0000_0000, 5'd0, 32'hFFFF_FFFF);
        offer(smr_pkg::OP_BUS_WRITE, smr_pkg::ADDR_M2S_CMD, 5'd0, 32'hFFFF_FFFF);
        offer(smr_pkg::OP_BUS_WRITE, smr_pkg::ADDR_S2M_CMD, 5'd0, 32'h5A5A_A5A5);
        offer(smr_pkg::OP_BUS_WRITE, smr_pkg::ADDR_MAIN_FLG, 5'd0, 32'h8000_0001);
        offer(smr_pkg::OP_BUS_WRITE, smr_pkg::ADDR_SUB_FLG, 5'd0, 32'h0002_0000);
        offer(smr_pkg::OP_BUS_WRITE, smr_pkg::ADDR_CONTROL, 5'd0, 32'hFFFF_FFFF);
        offer(smr_pkg::OP_BUS_WRITE, smr_pkg::ADDR_DESC, 5'd0, 32'h0000_0001);
        foreach (mapped_addr[i]) begin
            offer(smr_pkg::OP_BUS_READ, mapped_addr[i], 5'd31, 32'hFFFF_FFFF);
        end
        offer(smr_pkg::OP_SCRATCH_GET, 32'h0, smr_pkg::SCR_RAM_BASE, 32'h0);
        offer(smr_pkg::OP_SCRATCH_GET, 32'h0, smr_pkg::SCR_FLAG_A, 32'h0);
        offer(smr_pkg::OP_SCRATCH_GET, 32'h0, smr_pkg::SCR_FLAG_B, 32'h0);
        offer(smr_pkg::OP_SCRATCH_SET, smr_pkg::ADDR_DESC, 5'd31, 32'hFFFF_FFFF);
        offer(smr_pkg::OP_SCRATCH_GET, 32'hFFFF_FFFF, 5'd31, 32'h0);
        offer(smr_pkg::OP_SCRATCH_GET, 32'h0, 5'd0, 32'h0);
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            gaps_on = (phase == 0 || phase == 3);
            // back-to-back requests while the result side is held off
            if (phase == 2) hold_off_req = 1'b1;
            repeat (ITEMS_PER_PHASE) random_request();
            drain();
        end

        repeat (8) @(posedge aclk);
        $display("covered %0d requests: %0d bus reads, %0d bus writes, %0d scratch sets, %0d gets",
                 op_count[0] + op_count[1] + op_count[2] + op_count[3],
                 op_count[smr_pkg::OP_BUS_READ], op_count[smr_pkg::OP_BUS_WRITE],
                 op_count[smr_pkg::OP_SCRATCH_SET], op_count[smr_pkg::OP_SCRATCH_GET]);
        $display("%0d results compared, including a %0d-cycle result hold-off",
                 results_checked, HOLD_OFF_CYCLES);
        if (mismatches == 0 && outstanding == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/smr_pkg.sv
rtl/smr_ram.sv
rtl/subsystem_mailbox_registers.sv
rtl/smr_checker.sv
bench/mailbox_checker.sv
bench/subsystem_mailbox_registers_tb.sv
